FILE: hdl/est_pkg.sv
// Shared types, widths, codes and constant tables for the enveloped sine tone generator.
// Used by the channel interfaces, the controller, the datapath and the top level.
package est_pkg;

  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int COUNT_BITS_DEF   = 17;

  localparam int CMD_W      = 2;
  localparam int NOTE_W     = 7;
  localparam int STEP_W     = 32;
  localparam int LEN_W      = 17;
  localparam int VOL_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int MIN_W      = 12;
  localparam int RAMP_W     = 12;
  localparam int FRAC_W     = 16;
  localparam int ENV_W      = 17;
  localparam int MAG_W      = 15;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 17;
  localparam int DIV_CNT_W  = 5;

  localparam logic [MIN_W-1:0]  MIN_TONE_RST  = 12'd32;
  localparam logic [RAMP_W-1:0] MAX_RAMP_RST  = 12'd353;
  localparam logic [FRAC_W-1:0] RAMP_FRAC_RST = 16'd9830;

  localparam logic [LEN_W-1:0] NOTE_MIN_LEN = 17'd1323;
  localparam logic [LEN_W-1:0] NOTE_MAX_LEN = 17'd88200;
  localparam logic [ENV_W-1:0] ENV_ONE      = 17'h10000;
  localparam logic [VOL_W-1:0] VOL_MAX      = 16'h8000;
  localparam logic [MAG_W-1:0] MAG_MAX      = 15'd32767;

  localparam logic [63:0] A4STEP_Q8   = 64'd10970184041;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE = 2'd0,
    CMD_STEP = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_MIN_TONE  = 2'd0;
  localparam logic [1:0] REG_MAX_RAMP  = 2'd1;
  localparam logic [1:0] REG_RAMP_FRAC = 2'd2;

  localparam logic [31:0] SEMI [12] = '{
    32'd268435456, 32'd284397459, 32'd301308612, 32'd319225354,
    32'd338207482, 32'd358318345, 32'd379625062, 32'd402198743,
    32'd426114725, 32'd451452825, 32'd478297607, 32'd506738663
  };

  localparam logic [63:0] TAYLOR_DIV [6] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
  };

  typedef logic [STEP_W-1:0] note_tab_t [128];

  function automatic note_tab_t build_note_table();
    note_tab_t   tab;
    int          m;
    int          q;
    int          s;
    int          sh;
    logic [63:0] p;
    for (int n = 0; n < 128; n++) begin
      m  = n + 3;
      q  = m / 12;
      s  = m % 12;
      sh = 42 - q;
      p  = A4STEP_Q8 * {32'd0, SEMI[s]};
      tab[n] = STEP_W'((p + (64'd1 << (sh - 1))) >> sh);
    end
    return tab;
  endfunction

  localparam note_tab_t NOTE_STEP = build_note_table();

  typedef struct packed {
    logic load_start;
    logic ramp_calc;
    logic div_init;
    logic div_step;
    logic tk_env;
    logic tk_rom;
    logic tk_mul;
    logic tk_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_sample;
  } dp_stat_t;

endpackage

FILE: hdl/est_in_if.sv
// Input channel of the tone generator: valid/ready handshake with the start and tick fields.
// Depends on est_pkg for field widths.
interface est_in_if;
  logic                          valid;
  logic                          ready;
  logic [est_pkg::CMD_W-1:0]     command;
  logic [est_pkg::NOTE_W-1:0]    midi_note;
  logic [est_pkg::STEP_W-1:0]    phase_step;
  logic [est_pkg::LEN_W-1:0]     duration_samples;
  logic [est_pkg::VOL_W-1:0]     volume;

  modport source (output valid, command, midi_note, phase_step, duration_samples, volume,
                  input ready);
  modport sink (input valid, command, midi_note, phase_step, duration_samples, volume,
                output ready);
endinterface

FILE: hdl/est_out_if.sv
// Result channel of the tone generator: valid/ready handshake with one sample per word.
// Depends on est_pkg for field widths.
interface est_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [est_pkg::SAMPLE_W-1:0] sample;
  logic                               last;

  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

FILE: hdl/est_ctrl.sv
// Controller of the tone generator: one-hot sequencer for start setup, divider steps
// and the tick stages, plus the playing flag and the output valid. Depends on est_pkg.
module est_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [est_pkg::CMD_W-1:0]  in_cmd,
  output logic                       in_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output est_pkg::dp_cmd_t           cmd,
  input  est_pkg::dp_stat_t          stat
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RAMP = 8'b0000_0010,
    S_DIVI = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_TENV = 8'b0001_0000,
    S_TROM = 8'b0010_0000,
    S_TMUL = 8'b0100_0000,
    S_TOUT = 8'b1000_0000
  } state_t;

  localparam logic [est_pkg::DIV_CNT_W-1:0] DIV_LAST =
    est_pkg::DIV_CNT_W'(est_pkg::DIV_STEPS - 1);

  state_t                          state_r, state_nxt;
  logic [est_pkg::DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                            playing_r, playing_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            accept;
  logic                            out_free;
  logic                            is_start;
  logic                            is_tick;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_ready && in_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign is_start  = (in_cmd == est_pkg::CMD_NOTE) || (in_cmd == est_pkg::CMD_STEP);
  assign is_tick   = (in_cmd == est_pkg::CMD_TICK);

  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    playing_nxt   = playing_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && is_start) begin
          cmd.load_start = 1'b1;
          playing_nxt    = 1'b0;
          state_nxt      = S_RAMP;
        end else if (accept && is_tick && playing_r) begin
          state_nxt = S_TENV;
        end
      end
      S_RAMP: begin
        cmd.ramp_calc = 1'b1;
        state_nxt     = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          playing_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_TENV: begin
        cmd.tk_env = 1'b1;
        state_nxt  = S_TROM;
      end
      S_TROM: begin
        cmd.tk_rom = 1'b1;
        state_nxt  = S_TMUL;
      end
      S_TMUL: begin
        cmd.tk_mul = 1'b1;
        state_nxt  = S_TOUT;
      end
      S_TOUT: begin
        if (out_free) begin
          cmd.tk_commit = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last_sample) begin
            playing_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      playing_r   <= playing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tk_commit |-> (!out_valid_r || out_ready))
    else $error("Sample committed while the output word was still held.");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tk_commit && stat.last_sample) |=> !playing_r)
    else $error("Tone kept playing after its last sample.");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == DIV_LAST) |=> (playing_r && state_r == S_IDLE))
    else $error("Start setup did not end in playing idle state.");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_tick && !playing_r) |=> (state_r == S_IDLE))
    else $error("Tick while idle started sample work.");

endmodule

FILE: hdl/est_datapath.sv
// Datapath of the tone generator: start setup, ramp slope divider, envelope, sine table
// and gain multipliers, tone state and the output word register. Depends on est_pkg.
module est_datapath #(
  parameter int SINE_ENTRIES = est_pkg::SINE_ENTRIES_DEF,
  parameter int COUNT_BITS   = est_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  est_pkg::dp_cmd_t                  cmd,
  output est_pkg::dp_stat_t                 stat,
  input  logic [est_pkg::CMD_W-1:0]         in_command,
  input  logic [est_pkg::NOTE_W-1:0]        in_midi_note,
  input  logic [est_pkg::STEP_W-1:0]        in_phase_step,
  input  logic [est_pkg::LEN_W-1:0]         in_duration,
  input  logic [est_pkg::VOL_W-1:0]         in_volume,
  input  logic [est_pkg::MIN_W-1:0]         min_tone,
  input  logic [est_pkg::RAMP_W-1:0]        max_ramp,
  input  logic [est_pkg::FRAC_W-1:0]        ramp_frac,
  output logic signed [est_pkg::SAMPLE_W-1:0] out_sample,
  output logic                              out_last
);

  localparam int QUARTER_LEN = SINE_ENTRIES / 4;
  localparam int ROM_AW      = $clog2(QUARTER_LEN + 1);
  localparam int CW          = COUNT_BITS;
  localparam int LW          = (COUNT_BITS > est_pkg::LEN_W) ? COUNT_BITS : est_pkg::LEN_W;
  localparam int RW          = est_pkg::RAMP_W;
  localparam int EW          = est_pkg::ENV_W;
  localparam int MW          = est_pkg::MAG_W;
  localparam int FW          = est_pkg::FRAC_W;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  typedef logic [MW-1:0] rom_t [QUARTER_LEN + 1];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    for (int j = 0; j <= QUARTER_LEN; j++) begin
      x    = (64'(j) * est_pkg::HALF_PI_Q30) / QUARTER_LEN;
      sum  = x;
      term = x;
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / est_pkg::TAYLOR_DIV[k - 1];
        if ((k % 2) == 1) sum = sum - term;
        else              sum = sum + term;
      end
      v    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      t[j] = (v > 64'd32767) ? est_pkg::MAG_MAX : v[MW-1:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [CW-1:0]                 len_r;
  logic [est_pkg::STEP_W-1:0]    step_r;
  logic [est_pkg::VOL_W-1:0]     gain_r;
  logic [RW-1:0]                 ramp_r;
  logic [EW-1:0]                 slope_r;
  logic [RW-1:0]                 rem_r;
  logic [31:0]                   phase_r;
  logic [CW-1:0]                 index_r;
  logic [EW-1:0]                 env_r;
  logic [ROM_AW-1:0]             idx_r;
  logic [1:0]                    quad_r;
  logic [MW-1:0]                 mag_r;
  logic [31:0]                   p1_r;
  logic signed [est_pkg::SAMPLE_W-1:0] sample_r;
  logic                          last_r;

  logic [est_pkg::LEN_W-1:0]     len_req;
  logic [LW-1:0]                 len_wide;
  logic [CW-1:0]                 len_sat;
  logic [est_pkg::STEP_W-1:0]    step_sel;
  logic [est_pkg::VOL_W-1:0]     gain_sel;
  logic [CW+FW-1:0]              ramp_prod;
  logic [CW-1:0]                 ramp_q;
  logic [RW-1:0]                 ramp_nxt;
  logic [RW:0]                   div_trial;
  logic                          div_bit;
  logic [CW-1:0]                 ramp_ext;
  logic                          ramp_up;
  logic                          ramp_dn;
  logic [CW-1:0]                 len_left;
  logic [RW-1:0]                 env_op;
  logic [RW+EW-1:0]              env_prod;
  logic [EW-1:0]                 env_nxt;
  logic [30+ROM_AW-1:0]          frac_prod;
  logic [ROM_AW-1:0]             rom_addr;
  logic [47:0]                   p2;
  logic [16:0]                   scaled;
  logic [MW-1:0]                 mag_out;
  logic [est_pkg::SAMPLE_W-1:0]  sample_nxt;
  logic                          last_nxt;

  always_comb begin
    len_req = in_duration;
    if (in_command == est_pkg::CMD_NOTE) begin
      if (len_req < est_pkg::NOTE_MIN_LEN) len_req = est_pkg::NOTE_MIN_LEN;
      if (len_req > est_pkg::NOTE_MAX_LEN) len_req = est_pkg::NOTE_MAX_LEN;
    end
    if (len_req < est_pkg::LEN_W'(min_tone)) len_req = est_pkg::LEN_W'(min_tone);
    if (len_req == '0) len_req = est_pkg::LEN_W'(1);
    len_wide = LW'(len_req);
    len_sat  = (len_wide > LW'(COUNT_MAX)) ? COUNT_MAX : len_wide[CW-1:0];
    step_sel = (in_command == est_pkg::CMD_NOTE) ? est_pkg::NOTE_STEP[in_midi_note]
                                                 : in_phase_step;
    gain_sel = (in_volume > est_pkg::VOL_MAX) ? est_pkg::VOL_MAX : in_volume;
  end

  always_comb begin
    ramp_prod = {{FW{1'b0}}, len_r} * {{CW{1'b0}}, ramp_frac};
    ramp_q    = ramp_prod[CW+FW-1:FW];
    ramp_nxt  = (ramp_q > CW'(max_ramp)) ? max_ramp : ramp_q[RW-1:0];
    if (ramp_nxt == '0) ramp_nxt = RW'(1);
  end

  assign div_trial = {rem_r, slope_r[EW-1]};
  assign div_bit   = (div_trial >= {1'b0, ramp_r});

  always_comb begin
    ramp_ext = CW'(ramp_r);
    ramp_up  = (index_r < ramp_ext);
    ramp_dn  = ({1'b0, index_r} + {1'b0, ramp_ext}) > {1'b0, len_r};
    len_left = len_r - index_r;
    env_op   = ramp_up ? index_r[RW-1:0] : len_left[RW-1:0];
    env_prod = {{EW{1'b0}}, env_op} * {{RW{1'b0}}, slope_r};
    if (ramp_up || ramp_dn) begin
      env_nxt = (env_prod > (RW+EW)'(est_pkg::ENV_ONE)) ? est_pkg::ENV_ONE
                                                        : env_prod[EW-1:0];
    end else begin
      env_nxt = est_pkg::ENV_ONE;
    end
    frac_prod = {{ROM_AW{1'b0}}, phase_r[29:0]} * (30+ROM_AW)'(QUARTER_LEN);
  end

  assign rom_addr = quad_r[0] ? (ROM_AW'(QUARTER_LEN) - idx_r) : idx_r;

  always_comb begin
    p2         = {16'd0, p1_r} * {32'd0, gain_r};
    scaled     = p2[47:31];
    mag_out    = (scaled > 17'(est_pkg::MAG_MAX)) ? est_pkg::MAG_MAX : scaled[MW-1:0];
    sample_nxt = quad_r[1] ? (est_pkg::SAMPLE_W'(0) - {1'b0, mag_out}) : {1'b0, mag_out};
    last_nxt   = (({1'b0, index_r} + (CW+1)'(1)) == {1'b0, len_r});
  end

  assign stat.last_sample = last_nxt;
  assign out_sample       = sample_r;
  assign out_last         = last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      len_r   <= len_sat;
      step_r  <= step_sel;
      gain_r  <= gain_sel;
      phase_r <= '0;
      index_r <= '0;
    end
    if (cmd.ramp_calc) begin
      ramp_r <= ramp_nxt;
    end
    if (cmd.div_init) begin
      slope_r <= est_pkg::ENV_ONE + EW'(ramp_r[RW-1:1]);
      rem_r   <= '0;
    end
    if (cmd.div_step) begin
      slope_r <= {slope_r[EW-2:0], div_bit};
      rem_r   <= div_bit ? (div_trial[RW-1:0] - ramp_r) : div_trial[RW-1:0];
    end
    if (cmd.tk_env) begin
      env_r  <= env_nxt;
      idx_r  <= frac_prod[30 +: ROM_AW];
      quad_r <= phase_r[31:30];
    end
    if (cmd.tk_rom) begin
      mag_r <= SINE_ROM[rom_addr];
    end
    if (cmd.tk_mul) begin
      p1_r <= {{(32-MW){1'b0}}, mag_r} * {{(32-EW){1'b0}}, env_r};
    end
    if (cmd.tk_commit) begin
      sample_r <= sample_nxt;
      last_r   <= last_nxt;
      phase_r  <= phase_r + step_r;
      index_r  <= index_r + CW'(1);
    end
  end

  a_ramp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ramp_calc |=> (ramp_r != '0))
    else $error("Ramp length came out as zero.");

  a_env_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tk_env |=> (env_r <= est_pkg::ENV_ONE))
    else $error("Envelope exceeded full scale.");

endmodule

FILE: hdl/enveloped_sine_tone_generator.sv
// Top level of the enveloped sine tone generator: configuration registers on an APB-style
// port, controller and datapath. Depends on est_pkg, est_in_if, est_out_if, est_ctrl, est_datapath.
//
//  Channel   Direction  Handshake              Word
//  in_chan   in         valid/ready            command, midi_note, phase_step, duration, volume
//  out_chan  out        valid/ready            sample, last
//  cfg       in         psel/penable/pready    min_tone, max_ramp, ramp_fraction at 0, 4, 8
//
// A tick runs from acceptance to the output register through the envelope and phase index,
// sine table read, two gain multiplies. The next word can be taken in the cycle after that.
// A start loads the tone, sets the ramp and runs the 17-step one-bit-per-cycle slope divider.
// Input is accepted only while the sequencer is idle.
// A held output word stalls the next sample in its last stage; reset is synchronous and
// leaves the block idle with the register defaults.
module enveloped_sine_tone_generator #(
  parameter int SINE_ENTRIES = est_pkg::SINE_ENTRIES_DEF,
  parameter int COUNT_BITS   = est_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  est_in_if.sink                             in_chan,
  est_out_if.source                          out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [est_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [est_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [est_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic [est_pkg::MIN_W-1:0]  min_tone_r;
  logic [est_pkg::RAMP_W-1:0] max_ramp_r;
  logic [est_pkg::FRAC_W-1:0] ramp_frac_r;
  logic [1:0]                 reg_idx;
  logic                       cfg_write;
  est_pkg::dp_cmd_t           dp_cmd;
  est_pkg::dp_stat_t          dp_stat;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_tone_r  <= est_pkg::MIN_TONE_RST;
      max_ramp_r  <= est_pkg::MAX_RAMP_RST;
      ramp_frac_r <= est_pkg::RAMP_FRAC_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        est_pkg::REG_MIN_TONE:  min_tone_r  <= pwdata[est_pkg::MIN_W-1:0];
        est_pkg::REG_MAX_RAMP:  max_ramp_r  <= pwdata[est_pkg::RAMP_W-1:0];
        est_pkg::REG_RAMP_FRAC: ramp_frac_r <= pwdata[est_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      est_pkg::REG_MIN_TONE:  prdata = est_pkg::CFG_DATA_W'(min_tone_r);
      est_pkg::REG_MAX_RAMP:  prdata = est_pkg::CFG_DATA_W'(max_ramp_r);
      est_pkg::REG_RAMP_FRAC: prdata = est_pkg::CFG_DATA_W'(ramp_frac_r);
      default:                prdata = '0;
    endcase
  end

  est_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.command),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  est_datapath #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .in_command    (in_chan.command),
    .in_midi_note  (in_chan.midi_note),
    .in_phase_step (in_chan.phase_step),
    .in_duration   (in_chan.duration_samples),
    .in_volume     (in_chan.volume),
    .min_tone      (min_tone_r),
    .max_ramp      (max_ramp_r),
    .ramp_frac     (ramp_frac_r),
    .out_sample    (out_chan.sample),
    .out_last      (out_chan.last)
  );

endmodule

FILE: sim/tone_checker.sv
// Checker for the enveloped sine tone generator: watches the input, sample and register ports,
// predicts every sample from its own copy of the tone state and compares word by word.
// Depends on est_pkg, est_in_if and est_out_if.
module tone_checker
  import est_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  est_in_if                     in_mon,
  est_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    awaiting,
  output int                    samples_checked,
  output int                    tone_ends,
  output int                    words_used
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUARTER = SINE_ENTRIES_DEF / 4;
  localparam int IDX_W   = $clog2(QUARTER);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_word_t;

  logic [MAG_W-1:0]  quarter_sine [QUARTER+1];
  logic [MIN_W-1:0]  min_len;
  logic [RAMP_W-1:0] ramp_cap;
  logic [FRAC_W-1:0] ramp_frac;
  logic [STEP_W-1:0] phase_acc;
  logic [STEP_W-1:0] step_now;
  logic [LEN_W-1:0]  index_now;
  logic [LEN_W-1:0]  length_now;
  logic [LEN_W-1:0]  ramp_now;
  logic [ENV_W-1:0]  slope_now;
  logic [VOL_W-1:0]  gain_now;
  logic              playing;
  tone_word_t        due_words [$];
  int                n_bad;
  int                n_checked;
  int                n_ends;
  int                n_used;

  // The quarter-wave table comes from a seven-term Taylor series in Q30.
  initial begin
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    int          j;
    int          k;
    for (j = 0; j <= QUARTER; j++) begin
      x    = 64'(j) * HALF_PI_Q30 / 64'(QUARTER);
      sum  = x;
      term = x;
      for (k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / (64'(2 * k) * 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_sine[j] = (v > 64'd32767) ? MAG_MAX : MAG_W'(v);
    end
  end

  always @(posedge clk) begin
    tone_word_t        w;
    logic [LEN_W-1:0]  len;
    logic [STEP_W-1:0] step;
    logic [63:0]       prod;
    logic [63:0]       env;
    logic [63:0]       r;
    int                oct;
    int                semi;
    int                sh;
    int                idx;
    if (!rst_n) begin
      min_len    = MIN_TONE_RST;
      ramp_cap   = MAX_RAMP_RST;
      ramp_frac  = RAMP_FRAC_RST;
      phase_acc  = '0;
      step_now   = '0;
      index_now  = '0;
      length_now = '0;
      ramp_now   = '0;
      slope_now  = '0;
      gain_now   = '0;
      playing    = 1'b0;
      due_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_MIN_TONE:  min_len   = pwdata[MIN_W-1:0];
          REG_MAX_RAMP:  ramp_cap  = pwdata[RAMP_W-1:0];
          REG_RAMP_FRAC: ramp_frac = pwdata[FRAC_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (due_words.size() == 0) begin
          n_bad++;
          $display("%0t ns: expected no word, got sample %0d last %0b",
                   $time, out_mon.sample, out_mon.last);
        end else begin
          w = due_words.pop_front();
          n_checked++;
          if (w.last) n_ends++;
          if (out_mon.sample !== w.sample) begin
            n_bad++;
            $display("%0t ns: sample expected %0d, got %0d", $time, w.sample, out_mon.sample);
          end
          if (out_mon.last !== w.last) begin
            n_bad++;
            $display("%0t ns: last expected %0b, got %0b", $time, w.last, out_mon.last);
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_NOTE || in_mon.command == CMD_STEP) begin
          n_used++;
          len = in_mon.duration_samples;
          if (in_mon.command == CMD_NOTE) begin
            if (len < NOTE_MIN_LEN) len = NOTE_MIN_LEN;
            if (len > NOTE_MAX_LEN) len = NOTE_MAX_LEN;
            oct  = (int'(in_mon.midi_note) + 3) / 12;
            semi = (int'(in_mon.midi_note) + 3) % 12;
            sh   = 42 - oct;
            prod = A4STEP_Q8 * {32'd0, SEMI[semi]};
            step = STEP_W'((prod + (64'd1 << (sh - 1))) >> sh);
          end else begin
            step = in_mon.phase_step;
          end
          if (len < LEN_W'(min_len)) len = LEN_W'(min_len);
          if (len == '0) len = LEN_W'(1);
          r = (64'(len) * 64'(ramp_frac)) >> 16;
          if (r > 64'(ramp_cap)) r = 64'(ramp_cap);
          if (r == 64'd0) r = 64'd1;
          length_now = len;
          ramp_now   = LEN_W'(r);
          slope_now  = ENV_W'((64'd65536 + r / 2) / r);
          gain_now   = (in_mon.volume > VOL_MAX) ? VOL_MAX : in_mon.volume;
          step_now   = step;
          phase_acc  = '0;
          index_now  = '0;
          playing    = 1'b1;
        end else if (in_mon.command == CMD_TICK && playing) begin
          n_used++;
          if (index_now < ramp_now) begin
            env = 64'(index_now) * 64'(slope_now);
          end else if (index_now > length_now - ramp_now) begin
            env = 64'(length_now - index_now) * 64'(slope_now);
          end else begin
            env = 64'(ENV_ONE);
          end
          if (env > 64'(ENV_ONE)) env = 64'(ENV_ONE);
          idx = int'(phase_acc[29 -: IDX_W]);
          if (phase_acc[30]) idx = QUARTER - idx;
          prod = (64'(quarter_sine[idx]) * env * 64'(gain_now)) >> 31;
          if (prod > 64'd32767) prod = 64'd32767;
          w.sample = phase_acc[31] ? -SAMPLE_W'(prod) : SAMPLE_W'(prod);
          w.last   = (index_now + LEN_W'(1) == length_now);
          due_words.push_back(w);
          phase_acc = phase_acc + step_now;
          index_now = index_now + LEN_W'(1);
          if (index_now >= length_now) playing = 1'b0;
        end
      end
    end
    mismatches      <= n_bad;
    awaiting        <= due_words.size();
    samples_checked <= n_checked;
    tone_ends       <= n_ends;
    words_used      <= n_used;
  end

endmodule

FILE: sim/testbench.sv
// Top of the tone generator testbench: clock, reset, register writes, start and tick words,
// and random stalls on the sample channel. Checking is done by tone_checker.
// Depends on est_pkg, est_in_if, est_out_if, enveloped_sine_tone_generator and tone_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import est_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 90;
  localparam int HOLD_OFF    = 40;
  localparam int DRAIN_LIMIT = 4000;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    awaiting;
  int                    samples_checked;
  int                    tone_ends;
  int                    words_used;
  int                    words_sent;
  int                    stuck;
  int                    settings;
  logic                  calm_in;

  est_in_if  in_chan ();
  est_out_if out_chan ();

  enveloped_sine_tone_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tone_checker tone_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .samples_checked (samples_checked),
    .tone_ends       (tone_ends),
    .words_used      (words_used)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input cmd_t cmd, input logic [NOTE_W-1:0] note,
                           input logic [STEP_W-1:0] step, input logic [LEN_W-1:0] dur,
                           input logic [VOL_W-1:0] vol);
    int gap;
    if (words_sent % 24 == 0) calm_in = ($urandom_range(0, 3) == 0);
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.command          <= cmd;
    in_chan.midi_note        <= note;
    in_chan.phase_step       <= step;
    in_chan.duration_samples <= dur;
    in_chan.volume           <= vol;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
  endtask

  task automatic tick();
    send_word(CMD_TICK, NOTE_W'($urandom), $urandom, LEN_W'($urandom), VOL_W'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    int waited;
    in_chan.valid <= 1'b0;
    repeat (2) @(posedge clk);
    waited = 0;
    while (awaiting != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaiting != 0) stuck++;
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Mostly a start followed by a run of ticks, with some unused commands and stray ticks.
  task automatic play_phase(input int quota);
    int                base;
    int                run;
    int                pick;
    logic [LEN_W-1:0]  dur;
    logic [VOL_W-1:0]  vol;
    logic [STEP_W-1:0] step;
    base = words_used;
    while (words_used - base < quota) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_word(CMD_NOP, NOTE_W'($urandom), $urandom, LEN_W'($urandom), VOL_W'($urandom));
      end else if (pick == 1) begin
        tick();
      end else begin
        case ($urandom_range(0, 9))
          7, 8:    dur = LEN_W'($urandom);
          9:       dur = $urandom_range(0, 1) ? '1 : '0;
          default: dur = LEN_W'($urandom_range(0, 48));
        endcase
        case ($urandom_range(0, 9))
          6, 7:    vol = VOL_MAX;
          8, 9:    vol = VOL_W'($urandom);
          default: vol = VOL_W'($urandom_range(0, 32768));
        endcase
        step = $urandom >> $urandom_range(0, 31);
        send_word(($urandom_range(0, 2) == 0) ? CMD_NOTE : CMD_STEP, NOTE_W'($urandom), step,
                  dur, vol);
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
        repeat (run) tick();
      end
    end
  endtask

  initial begin
    int    stall;
    int    taken;
    logic  calm_out;
    out_chan.ready = 1'b0;
    taken = 0;
    calm_out = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 24 == 0) calm_out = ($urandom_range(0, 3) == 0);
      stall = calm_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      taken++;
    end
  end

  initial begin
    logic [MIN_W-1:0]  min_tone;
    logic [RAMP_W-1:0] max_ramp;
    logic [FRAC_W-1:0] frac;
    int                p;
    in_chan.valid            = 1'b0;
    in_chan.command          = CMD_TICK;
    in_chan.midi_note        = '0;
    in_chan.phase_step       = '0;
    in_chan.duration_samples = '0;
    in_chan.volume           = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    words_sent = 0;
    stuck      = 0;
    settings   = 0;
    calm_in    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tick();
    send_word(CMD_NOP, '1, '1, '1, '1);
    send_word(CMD_NOTE, 7'd0, '1, 17'd0, VOL_MAX);
    repeat (2) tick();
    send_word(CMD_NOTE, 7'd127, '0, '1, 16'hFFFF);
    repeat (2) tick();
    send_word(CMD_NOTE, 7'd69, '0, 17'd5000, '0);
    tick();
    send_word(CMD_STEP, '0, 32'h4000_0000, 17'd1, VOL_MAX);
    repeat (4) tick();
    send_word(CMD_STEP, '1, '1, '1, '0);
    tick();
    send_word(CMD_STEP, '0, '0, '0, 16'd1);
    tick();
    send_word(CMD_NOP, '0, '0, '0, '0);
    tick();
    settle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          min_tone = 12'd1;
          max_ramp = 12'd1;
          frac     = 16'd0;
        end
        1: begin
          min_tone = 12'd4095;
          max_ramp = 12'd4095;
          frac     = 16'hFFFF;
        end
        2: begin
          min_tone = 12'd1;
          max_ramp = 12'd4095;
          frac     = 16'hFFFF;
        end
        3: begin
          min_tone = MIN_TONE_RST;
          max_ramp = MAX_RAMP_RST;
          frac     = RAMP_FRAC_RST;
        end
        default: begin
          min_tone = MIN_W'($urandom_range(0, 48));
          max_ramp = RAMP_W'($urandom_range(0, 4095));
          frac     = FRAC_W'($urandom);
        end
      endcase
      write_reg(REG_MIN_TONE, {20'($urandom), min_tone});
      write_reg(REG_MAX_RAMP, {20'($urandom), max_ramp});
      write_reg(REG_RAMP_FRAC, {16'($urandom), frac});
      settings++;
      play_phase(PHASE_WORDS);
      settle();
    end

    $display("Covered %0d start and playing tick words under %0d register settings;",
             words_used, settings + 1);
    $display("%0d samples checked, %0d tones played to their last sample.",
             samples_checked, tone_ends);
    if (mismatches == 0 && awaiting == 0 && stuck == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
